// ----- design/plfgt_pkg.sv -----
package plfgt_pkg;

    // tree and list dimensions
    localparam int unsigned LIST_SIZE   = 4;
    localparam int unsigned CODE_LENGTH = 16;
    localparam int unsigned TREE_LEVELS = 4;
    localparam int unsigned COST_WIDTH  = 8;
    localparam int unsigned CHAN_WIDTH  = 6;

    // derived sizes
    localparam int unsigned NODES      = CODE_LENGTH - 1;
    localparam int unsigned LEAF_NODES = CODE_LENGTH / 2;
    localparam int unsigned LEAF_BASE  = LEAF_NODES - 1;
    localparam int unsigned PTR_BITS   = 2;
    localparam int unsigned PTR_LANE_W = PTR_BITS * (TREE_LEVELS - 1);
    localparam int unsigned LIST_W     = $clog2(LIST_SIZE);
    localparam int unsigned CIDX_W     = $clog2(CODE_LENGTH);

    // request field widths
    localparam int unsigned PTR_FIELD_W  = 24;
    localparam int unsigned PART_FIELD_W = 60;

    // request kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef logic [COST_WIDTH-1:0]   cost_t;
    typedef logic [COST_WIDTH:0]     sum_t;
    typedef logic [CHAN_WIDTH-1:0]   chan_t;
    typedef cost_t [NODES-1:0]       node_vec_t;
    typedef node_vec_t [LIST_SIZE-1:0] list_vec_t;
    typedef chan_t [CODE_LENGTH-1:0] chan_vec_t;
    typedef cost_t [LIST_SIZE-1:0]   root_vec_t;

    typedef struct packed {
        cost_t c0;
        cost_t c1;
    } pe_res_t;

    // output sequencer status towards the request side
    typedef struct packed {
        logic busy;
        logic take_last;
    } merge_stat_t;

    // one processing element: f is min-sum, g is partial-sum combine
    function automatic pe_res_t pe_compute(cost_t a0, cost_t a1, cost_t b0, cost_t b1,
                                           logic g_mode, logic pbit);
        sum_t    s00;
        sum_t    s11;
        sum_t    s01;
        sum_t    s10;
        pe_res_t r;
        s00 = sum_t'(a0) + sum_t'(b0);
        s11 = sum_t'(a1) + sum_t'(b1);
        s01 = sum_t'(a0) + sum_t'(b1);
        s10 = sum_t'(a1) + sum_t'(b0);
        if (!g_mode)
        begin
            r.c0 = cost_t'((s00 > s11) ? s11 : s00);
            r.c1 = cost_t'((s01 > s10) ? s10 : s01);
        end
        else if (!pbit)
        begin
            r.c0 = cost_t'(s00);
            r.c1 = cost_t'(s11);
        end
        else
        begin
            r.c0 = cost_t'(s10);
            r.c1 = cost_t'(s01);
        end
        return r;
    endfunction

endpackage

// ----- design/plfgt_if.sv -----
// request channel
interface plfgt_in_if
    import plfgt_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [CIDX_W-1:0]       chan_index;
    logic [CHAN_WIDTH-1:0]   chan_cost0;
    logic [CHAN_WIDTH-1:0]   chan_cost1;
    logic [TREE_LEVELS-1:0]  level_enable;
    logic [TREE_LEVELS-1:0]  level_mode;
    logic [PTR_FIELD_W-1:0]  path_pointers;
    logic [PART_FIELD_W-1:0] partial_bits;

    modport source (output valid, kind, chan_index, chan_cost0, chan_cost1,
                    level_enable, level_mode, path_pointers, partial_bits,
                    input ready);
    modport sink   (input valid, kind, chan_index, chan_cost0, chan_cost1,
                    level_enable, level_mode, path_pointers, partial_bits,
                    output ready);
endinterface

// result channel
interface plfgt_out_if
    import plfgt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [LIST_W-1:0] list_index;
    logic [COST_WIDTH-1:0] root_cost0;
    logic [COST_WIDTH-1:0] root_cost1;
    logic              last;

    modport source (output valid, list_index, root_cost0, root_cost1, last,
                    input ready);
    modport sink   (input valid, list_index, root_cost0, root_cost1, last,
                    output ready);
endinterface

// ----- design/polar_list_f_g_tree_update.sv -----
// requests: a load request gives no result; an update request writes every enabled node
// at its accepting edge and the first result follows next cycle
// throughput: one result per cycle unless result.ready stalls it, LIST_SIZE results per
// update, set by the single result channel; updates and loads wait while results pend
// reset: node costs clear to zero, the channel store is not cleared, no result pending
module polar_list_f_g_tree_update
    import plfgt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    plfgt_in_if.sink   item,
    plfgt_out_if.source result
);

    logic        take_item;
    logic        update;
    merge_stat_t stat;
    chan_vec_t   chan0_reg;
    chan_vec_t   chan1_reg;
    list_vec_t   all_cost0;
    list_vec_t   all_cost1;
    root_vec_t   roots0;
    root_vec_t   roots1;

    // a new update waits until the last result of the previous one leaves
    assign item.ready = ~stat.busy | stat.take_last;
    assign take_item  = item.valid & item.ready;
    assign update     = take_item & (item.kind == KIND_UPDATE);

    // channel cost store, out-of-range indexes ignored
    always_ff @(posedge clk)
    begin
        if (take_item && (item.kind == KIND_LOAD) && (32'(item.chan_index) < CODE_LENGTH))
        begin
            chan0_reg[item.chan_index] <= item.chan_cost0;
            chan1_reg[item.chan_index] <= item.chan_cost1;
        end
    end

    // one lane per list
    for (genvar l = 0; l < LIST_SIZE; l++)
    begin : g_lane
        plfgt_lane #(
            .LANE (l)
        ) u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .update       (update),
            .level_enable (item.level_enable),
            .level_mode   (item.level_mode),
            .ptrs         (item.path_pointers[PTR_LANE_W*l +: PTR_LANE_W]),
            .parts        (item.partial_bits[NODES*l +: NODES]),
            .all_cost0    (all_cost0),
            .all_cost1    (all_cost1),
            .chan0        (chan0_reg),
            .chan1        (chan1_reg),
            .cost0        (all_cost0[l]),
            .cost1        (all_cost1[l])
        );
        assign roots0[l] = all_cost0[l][0];
        assign roots1[l] = all_cost1[l][0];
    end

    // result sequencer across lanes
    plfgt_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (update),
        .roots0 (roots0),
        .roots1 (roots1),
        .result (result),
        .stat   (stat)
    );

endmodule

// ----- design/plfgt_lane.sv -----
module plfgt_lane
    import plfgt_pkg::*;
#(
    parameter int unsigned LANE = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   update,
    input  logic [TREE_LEVELS-1:0] level_enable,
    input  logic [TREE_LEVELS-1:0] level_mode,
    input  logic [PTR_LANE_W-1:0]  ptrs,
    input  logic [NODES-1:0]       parts,
    input  list_vec_t              all_cost0,
    input  list_vec_t              all_cost1,
    input  chan_vec_t              chan0,
    input  chan_vec_t              chan1,
    output node_vec_t              cost0,
    output node_vec_t              cost1
);

    pe_res_t   res [NODES];
    logic      en  [NODES];
    node_vec_t cost0_reg;
    node_vec_t cost1_reg;
    node_vec_t cost0_next;
    node_vec_t cost1_next;

    // one processing element per node, all reading the values held before the update
    for (genvar n = 0; n < NODES; n++)
    begin : g_node
        localparam int unsigned LVL = $clog2(n + 2) - 1;
        if (n >= LEAF_BASE)
        begin : g_leaf
            localparam int unsigned W = n - LEAF_BASE;
            assign en[n]  = update & level_enable[TREE_LEVELS-1];
            assign res[n] = pe_compute(cost_t'(chan0[2*W]), cost_t'(chan1[2*W]),
                                       cost_t'(chan0[2*W+1]), cost_t'(chan1[2*W+1]),
                                       level_mode[TREE_LEVELS-1], parts[n]);
        end
        else
        begin : g_inner
            logic [LIST_W-1:0] src;
            // g nodes read the children of the list that the path pointer names
            assign src = level_mode[LVL]
                       ? LIST_W'(ptrs[PTR_BITS*LVL +: PTR_BITS] % LIST_SIZE)
                       : LIST_W'(LANE);
            assign en[n]  = update & level_enable[LVL];
            assign res[n] = pe_compute(all_cost0[src][2*n+1], all_cost1[src][2*n+1],
                                       all_cost0[src][2*n+2], all_cost1[src][2*n+2],
                                       level_mode[LVL], parts[n]);
        end
    end

    // enabled nodes take the new pair
    always_comb
    begin
        cost0_next = cost0_reg;
        cost1_next = cost1_reg;
        for (int n = 0; n < NODES; n++)
        begin
            if (en[n])
            begin
                cost0_next[n] = res[n].c0;
                cost1_next[n] = res[n].c1;
            end
        end
    end

    // node cost store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost0_reg <= '0;
            cost1_reg <= '0;
        end
        else
        begin
            cost0_reg <= cost0_next;
            cost1_reg <= cost1_next;
        end
    end

    assign cost0 = cost0_reg;
    assign cost1 = cost1_reg;

endmodule

// ----- design/plfgt_merge.sv -----
module plfgt_merge
    import plfgt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  root_vec_t    roots0,
    input  root_vec_t    roots1,
    plfgt_out_if.source  result,
    output merge_stat_t  stat
);

    logic              busy_reg;
    logic              busy_next;
    logic [LIST_W-1:0] cnt_reg;
    logic [LIST_W-1:0] cnt_next;
    logic              take;
    logic              at_last;

    assign take    = result.valid & result.ready;
    assign at_last = (cnt_reg == LIST_W'(LIST_SIZE - 1));

    // walk the lanes in ascending list order
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (take && at_last)
        begin
            busy_next = 1'b0;
        end
        else if (take)
        begin
            cnt_next = cnt_reg + LIST_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // root costs of the selected lane
    assign result.valid      = busy_reg;
    assign result.list_index = cnt_reg;
    assign result.root_cost0 = roots0[cnt_reg];
    assign result.root_cost1 = roots1[cnt_reg];
    assign result.last       = at_last;

    assign stat.busy      = busy_reg;
    assign stat.take_last = take & at_last;

endmodule

// ----- design/plfgt_checker.sv -----
module plfgt_checker
    import plfgt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              item_kind,
    input logic              res_valid,
    input logic              res_ready,
    input logic [LIST_W-1:0] res_list_index,
    input logic              res_last
);

    // results of one update come in ascending list order
    a_list_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last
        |=> res_valid && (res_list_index == $past(res_list_index) + LIST_W'(1)))
        else $error("result list order broken");

    // an accepted update starts its results at the first list
    a_update_start: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_kind == KIND_UPDATE)
        |=> res_valid && (res_list_index == '0))
        else $error("update did not start results at list zero");

    // no request taken while results are still pending
    a_hold_off: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !(res_ready && res_last) |-> !item_ready)
        else $error("request taken while results pending");

    // last marks exactly the final list
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_last == (res_list_index == LIST_W'(LIST_SIZE - 1))))
        else $error("last flag on wrong list");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_list_index))
        else $error("stalled result changed");

endmodule

bind polar_list_f_g_tree_update plfgt_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_kind      (item.kind),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_list_index (result.list_index),
    .res_last       (result.last)
);
